// ===== rtl/wbta_pkg.sv =====
`timescale 1ns / 1ps
// wbta_pkg: shared types, constants and helpers for the task assigner
// depends on nothing; imported by every rtl module of the block

package wbta_pkg;

    localparam int ACT_W   = 2;
    localparam int TC_W    = 5;
    localparam int WGT_W   = 32;
    localparam int IDX_W   = 4;
    localparam int SUM_BITS = 44;
    localparam int PROD_W  = SUM_BITS + 1 + TC_W;
    localparam int S_DATA_W = 40;
    localparam int M_DATA_W = 8;

    localparam logic [SUM_BITS-1:0] SUM_MAX = '1;

    localparam logic [ACT_W-1:0] ACT_CLEAR  = 2'd0;
    localparam logic [ACT_W-1:0] ACT_LOAD   = 2'd1;
    localparam logic [ACT_W-1:0] ACT_ASSIGN = 2'd2;

    typedef struct packed {
        logic start;
        logic flush;
    } t_scan_ctl;

    typedef struct packed {
        logic act;
        logic gt;
        logic lt;
    } t_scan_flag;

    function automatic logic [SUM_BITS-1:0] sat_add(
        input logic [SUM_BITS-1:0] a,
        input logic [WGT_W-1:0]    b
    );
        logic [SUM_BITS:0] s;
        s = {1'b0, a} + (SUM_BITS+1)'(b);
        return s[SUM_BITS] ? SUM_MAX : s[SUM_BITS-1:0];
    endfunction

endpackage

// ===== rtl/workload_balanced_task_assigner_core.sv =====
`timescale 1ns / 1ps
// workload_balanced_task_assigner_core: greedy task-to-thread assigner, top level
// uses wbta_pkg, wbta_load_mem and wbta_scan
//
// channel  dir  handshake            payload
// s        in   i_s_tvalid/o_s_tready  action, task_weight
// m        out  o_m_tvalid/i_m_tready  thread_index
// cfg      in   i_cfg_we               thread_count
//
// clear and load are each taken in the idle state
// assign reads the load memory at most once per active thread and passes each
// load through the memory read register and the s1 and s2 test stages, then
// writes the chosen thread's new load back in the write-back state
// an early hit in the scan ends the pass at once
// the result waits in an output register; a stalled result holds only the
// write-back of the next assign
// reset is synchronous, active low; no clearing pass is needed

module workload_balanced_task_assigner_core #(
    parameter int MAX_THREADS = 16,
    parameter int WEIGHT_BITS = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [wbta_pkg::S_DATA_W-1:0] i_s_tdata,  // action, task_weight
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [wbta_pkg::M_DATA_W-1:0] o_m_tdata,  // thread_index
    input  logic                          i_cfg_we,
    input  logic [wbta_pkg::TC_W-1:0]     i_cfg_wdata
);
    import wbta_pkg::*;

    localparam int TW = (MAX_THREADS > 1) ? $clog2(MAX_THREADS) : 1;
    localparam int CW = (TW > TC_W) ? TW : TC_W;
    localparam int WB = (WEIGHT_BITS < WGT_W) ? WEIGHT_BITS : WGT_W;
    localparam logic [WGT_W-1:0] W_MASK = WGT_W'((64'd1 << WB) - 64'd1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_WB   = 2'd2;

    logic [1:0]          r_state, n_state;
    logic [TC_W-1:0]     r_tc;
    logic [SUM_BITS-1:0] r_total, n_total;
    logic [TW-1:0]       r_cur, n_cur;
    logic [TC_W-1:0]     r_n, n_n;
    logic [WGT_W-1:0]    r_w, n_w;
    logic [TW-1:0]       r_iss_addr, n_iss_addr;
    logic [TC_W-1:0]     r_iss_left, n_iss_left;
    logic [TC_W-1:0]     r_chk_left, n_chk_left;
    logic [TW-1:0]       r_ch_idx, n_ch_idx;
    logic [SUM_BITS-1:0] r_ch_ld, n_ch_ld;
    logic                r_out_vld, n_out_vld;
    logic [IDX_W-1:0]    r_out_idx, n_out_idx;

    logic [ACT_W-1:0]    in_act;
    logic [WGT_W-1:0]    in_w;
    logic                in_go, wb_go, hit;
    logic [TC_W-1:0]     n_calc;
    logic [TW-1:0]       cur0;
    t_scan_ctl           ctl;
    t_scan_flag          flag;
    logic                mem_clr, mem_we, rd_en;
    logic [TW-1:0]       rd_addr, s_idx, min_idx;
    logic [SUM_BITS-1:0] mem_wdata, rd_ld, s_ld, min_ld;

    function automatic logic [TW-1:0] next_thr(
        input logic [TW-1:0]   a,
        input logic [TC_W-1:0] n
    );
        logic [CW-1:0] s;
        s = CW'(a) + CW'(1);
        return (s == CW'(n)) ? '0 : TW'(s);
    endfunction

    assign in_act = i_s_tdata[ACT_W-1:0];
    assign in_w   = i_s_tdata[ACT_W+WGT_W-1:ACT_W] & W_MASK;
    assign in_go  = i_s_tvalid && (r_state == ST_IDLE);
    assign wb_go  = !r_out_vld || i_m_tready;
    assign hit    = (r_chk_left == r_n) ? !flag.gt : flag.lt;

    always_comb begin
        if (r_tc == '0) begin
            n_calc = TC_W'(1);
        end else if (int'(r_tc) > MAX_THREADS) begin
            n_calc = TC_W'(MAX_THREADS);
        end else begin
            n_calc = r_tc;
        end
        cur0 = (CW'(r_cur) < CW'(n_calc)) ? r_cur : '0;
    end

    always_comb begin
        n_state    = r_state;
        n_total    = r_total;
        n_cur      = r_cur;
        n_n        = r_n;
        n_w        = r_w;
        n_iss_addr = r_iss_addr;
        n_iss_left = r_iss_left;
        n_chk_left = r_chk_left;
        n_ch_idx   = r_ch_idx;
        n_ch_ld    = r_ch_ld;
        n_out_vld  = r_out_vld;
        n_out_idx  = r_out_idx;
        ctl        = '0;
        mem_clr    = 1'b0;
        mem_we     = 1'b0;
        mem_wdata  = sat_add(r_ch_ld, r_w);
        rd_en      = 1'b0;
        rd_addr    = cur0;

        if (r_out_vld && i_m_tready) begin
            n_out_vld = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (in_go) begin
                    unique case (in_act)
                        ACT_CLEAR: begin
                            n_total = '0;
                            n_cur   = '0;
                            mem_clr = 1'b1;
                        end
                        ACT_LOAD: begin
                            n_total = sat_add(r_total, in_w);
                        end
                        ACT_ASSIGN: begin
                            n_state    = ST_SCAN;
                            n_n        = n_calc;
                            n_w        = in_w;
                            rd_en      = 1'b1;
                            n_iss_addr = next_thr(cur0, n_calc);
                            n_iss_left = n_calc - TC_W'(1);
                            n_chk_left = n_calc;
                            ctl.start  = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                if (r_iss_left != '0) begin
                    rd_en      = 1'b1;
                    rd_addr    = r_iss_addr;
                    n_iss_addr = next_thr(r_iss_addr, r_n);
                    n_iss_left = r_iss_left - TC_W'(1);
                end
                if (flag.act) begin
                    n_chk_left = r_chk_left - TC_W'(1);
                    if (hit) begin
                        n_ch_idx  = s_idx;
                        n_ch_ld   = s_ld;
                        n_state   = ST_WB;
                        ctl.flush = 1'b1;
                    end else if (r_chk_left == TC_W'(1)) begin
                        n_ch_idx  = min_idx;
                        n_ch_ld   = min_ld;
                        n_state   = ST_WB;
                        ctl.flush = 1'b1;
                    end
                end
            end
            ST_WB: begin
                if (wb_go) begin
                    mem_we    = 1'b1;
                    n_cur     = r_ch_idx;
                    n_out_vld = 1'b1;
                    n_out_idx = IDX_W'(r_ch_idx);
                    n_state   = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_tc       <= TC_W'(1);
            r_total    <= '0;
            r_cur      <= '0;
            r_iss_left <= '0;
            r_chk_left <= '0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_total    <= n_total;
            r_cur      <= n_cur;
            r_iss_left <= n_iss_left;
            r_chk_left <= n_chk_left;
            r_out_vld  <= n_out_vld;
            if (i_cfg_we) begin
                r_tc <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_n        <= n_n;
        r_w        <= n_w;
        r_iss_addr <= n_iss_addr;
        r_ch_idx   <= n_ch_idx;
        r_ch_ld    <= n_ch_ld;
        r_out_idx  <= n_out_idx;
    end

    wbta_load_mem #(
        .DEPTH (MAX_THREADS),
        .AW    (TW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clr   (mem_clr),
        .i_we    (mem_we),
        .i_waddr (r_ch_idx),
        .i_wdata (mem_wdata),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (rd_ld)
    );

    wbta_scan #(
        .AW (TW)
    ) u_scan (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (ctl),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .i_rd_ld   (rd_ld),
        .i_w       (r_w),
        .i_n       (r_n),
        .i_total   (r_total),
        .o_flag    (flag),
        .o_idx     (s_idx),
        .o_ld      (s_ld),
        .o_min_idx (min_idx),
        .o_min_ld  (min_ld)
    );

    assign o_s_tready = (r_state == ST_IDLE);
    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = M_DATA_W'(r_out_idx);

    a_scan_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> (r_chk_left != '0))
        else $error("scan running with no result left to check");

    a_choice_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WB) |-> (CW'(r_ch_idx) < CW'(r_n)))
        else $error("chosen thread outside the active range");

    a_cur_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WB && wb_go) |=> (r_cur == $past(r_ch_idx) && o_m_tvalid))
        else $error("write-back did not update current thread and result");

    a_no_read_outside_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WB) |-> (!rd_en && !flag.act))
        else $error("load read or test result live during write-back");

endmodule

// ===== rtl/wbta_load_mem.sv =====
`timescale 1ns / 1ps
// wbta_load_mem: per-thread load memory, one write and one registered read port
// valid bits make cleared entries read as zero; uses wbta_pkg

module wbta_load_mem #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_clr,
    input  logic                          i_we,
    input  logic [AW-1:0]                 i_waddr,
    input  logic [wbta_pkg::SUM_BITS-1:0] i_wdata,
    input  logic                          i_re,
    input  logic [AW-1:0]                 i_raddr,
    output logic [wbta_pkg::SUM_BITS-1:0] o_rdata
);
    import wbta_pkg::*;

    logic [SUM_BITS-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0]    r_vld;
    logic [SUM_BITS-1:0] r_q;
    logic                r_q_vld;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_q <= r_mem[i_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clr) begin
            r_vld   <= '0;
            r_q_vld <= 1'b0;
        end else begin
            if (i_we) begin
                r_vld[i_waddr] <= 1'b1;
            end
            if (i_re) begin
                r_q_vld <= r_vld[i_raddr];
            end
        end
    end

    assign o_rdata = r_q_vld ? r_q : '0;

endmodule

// ===== rtl/wbta_scan.sv =====
`timescale 1ns / 1ps
// wbta_scan: pipelined average test over loads read back from the load memory
// tracks the lowest-index least-loaded thread; uses wbta_pkg

module wbta_scan #(
    parameter int AW = 4
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  wbta_pkg::t_scan_ctl           i_ctl,
    input  logic                          i_rd_en,
    input  logic [AW-1:0]                 i_rd_addr,
    input  logic [wbta_pkg::SUM_BITS-1:0] i_rd_ld,
    input  logic [wbta_pkg::WGT_W-1:0]    i_w,
    input  logic [wbta_pkg::TC_W-1:0]     i_n,
    input  logic [wbta_pkg::SUM_BITS-1:0] i_total,
    output wbta_pkg::t_scan_flag          o_flag,
    output logic [AW-1:0]                 o_idx,
    output logic [wbta_pkg::SUM_BITS-1:0] o_ld,
    output logic [AW-1:0]                 o_min_idx,
    output logic [wbta_pkg::SUM_BITS-1:0] o_min_ld
);
    import wbta_pkg::*;

    logic                r_q_act, r_s1_act, r_s2_act, r_min_any;
    logic [AW-1:0]       r_q_idx, r_s1_idx, r_s2_idx, r_min_idx;
    logic [SUM_BITS-1:0] r_s1_ld, r_s2_ld, r_min_ld;
    logic [SUM_BITS:0]   r_s1_sum;
    logic [PROD_W-1:0]   r_s2_prod;
    logic                min_upd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_act   <= 1'b0;
            r_s1_act  <= 1'b0;
            r_s2_act  <= 1'b0;
            r_min_any <= 1'b0;
        end else begin
            r_q_act  <= i_rd_en && !i_ctl.flush;
            r_s1_act <= r_q_act && !i_ctl.flush;
            r_s2_act <= r_s1_act && !i_ctl.flush;
            if (i_ctl.start) begin
                r_min_any <= 1'b0;
            end else if (r_s2_act) begin
                r_min_any <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_q_idx   <= i_rd_addr;
        r_s1_idx  <= r_q_idx;
        r_s1_ld   <= i_rd_ld;
        r_s1_sum  <= {1'b0, i_rd_ld} + (SUM_BITS+1)'(i_w);
        r_s2_idx  <= r_s1_idx;
        r_s2_ld   <= r_s1_ld;
        r_s2_prod <= PROD_W'(i_n) * PROD_W'(r_s1_sum);
        if (min_upd) begin
            r_min_idx <= r_s2_idx;
            r_min_ld  <= r_s2_ld;
        end
    end

    assign min_upd = r_s2_act && (!r_min_any || (r_s2_ld < r_min_ld)
                     || ((r_s2_ld == r_min_ld) && (r_s2_idx < r_min_idx)));

    assign o_flag.act = r_s2_act;
    assign o_flag.gt  = r_s2_prod > PROD_W'(i_total);
    assign o_flag.lt  = r_s2_prod < PROD_W'(i_total);
    assign o_idx      = r_s2_idx;
    assign o_ld       = r_s2_ld;
    assign o_min_idx  = min_upd ? r_s2_idx : r_min_idx;
    assign o_min_ld   = min_upd ? r_s2_ld : r_min_ld;

endmodule
